/* hdl/tpv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tpv_pkg;

    localparam int PIX_W   = 8;
    localparam int SUM_W   = 16;
    localparam int SQ_W    = 24;
    localparam int VAR_W   = 32;
    localparam int DIM_W   = 11;
    localparam int CNT_W   = 9;
    localparam int PDATA_W = 32;
    localparam int PADDR_W = 4;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_COUNT  = 2'd2;

    // Per-item control that travels with the pixel through the pipeline.
    typedef struct packed {
        logic first;  // first frame of the sequence: overwrite the stores
        logic emit;   // last frame of the sequence: produce a result
        logic fin;    // final pixel of the frame
    } t_tag;

endpackage

`default_nettype wire

/* hdl/tpv_accum.sv */
`timescale 1ns / 1ps
`default_nettype none

module tpv_accum #(
    parameter int DEPTH = 1048576
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_valid,
    output logic                                 o_ready,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire  [tpv_pkg::PIX_W-1:0]            i_pixel,
    input  wire  tpv_pkg::t_tag                  i_tag,
    output logic                                 o_valid,
    input  wire                                  i_ready,
    output logic [tpv_pkg::SUM_W-1:0]            o_sum,
    output logic [tpv_pkg::SQ_W-1:0]             o_sq,
    output tpv_pkg::t_tag                        o_tag
);
    import tpv_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MW = SUM_W + SQ_W;

    logic [MW-1:0]    r_mem [DEPTH];
    logic [MW-1:0]    r_rd;
    logic [MW-1:0]    r_fwd_data;
    logic             r_fwd;
    logic             r_v1;
    logic [AW-1:0]    r_addr;
    logic [PIX_W-1:0] r_pix;
    t_tag             r_tag;

    logic             accept;
    logic             wr_en;
    logic [MW-1:0]    base;
    logic [2*PIX_W-1:0] pix_sq;
    logic [SUM_W-1:0] cur_sum;
    logic [SQ_W-1:0]  cur_sq;

    assign o_ready = !r_v1 || i_ready;
    assign accept  = i_valid && o_ready;
    assign wr_en   = r_v1 && i_ready;

    // The entry being written back on the same edge as a new read would be
    // read stale, so its fresh value is captured beside the read data.
    assign base   = r_fwd ? r_fwd_data : r_rd;
    assign pix_sq = r_pix * r_pix;

    always_comb begin
        if (r_tag.first) begin
            cur_sum = SUM_W'(r_pix);
            cur_sq  = SQ_W'(pix_sq);
        end else begin
            cur_sum = base[MW-1:SQ_W] + SUM_W'(r_pix);
            cur_sq  = base[SQ_W-1:0] + SQ_W'(pix_sq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_addr] <= {cur_sum, cur_sq};
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_ready) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr     <= i_addr;
            r_pix      <= i_pixel;
            r_tag      <= i_tag;
            r_fwd      <= wr_en && (r_addr == i_addr);
            r_fwd_data <= {cur_sum, cur_sq};
        end
    end

    assign o_valid = r_v1;
    assign o_sum   = cur_sum;
    assign o_sq    = cur_sq;
    assign o_tag   = r_tag;

endmodule

`default_nettype wire

/* hdl/temporal_pixel_variance.sv */
`timescale 1ns / 1ps
`default_nettype none

// Per-pixel temporal variance over a sequence of 8-bit frames. Pixels arrive
// in raster order, frame after frame; every position keeps a 16-bit sum and a
// 24-bit sum of squares in an internal RAM of MAX_WIDTH*MAX_HEIGHT 40-bit
// words, and during the last frame of each sequence every pixel yields
// frame_count*sumsq - sum*sum, with o_last set on the final pixel. The block
// takes one pixel per clock unless i_stall holds the output: the RAM read for
// a pixel is issued as it is accepted and its write-back happens as it leaves
// the update stage, with a bypass covering back-to-back hits on the same
// position, so a frame of a single pixel also runs at full rate. A result
// passes through the update stage and the sum, product and output registers.
// No clearing pass is needed after reset, since the first frame of a sequence
// overwrites every entry before it is read. Writing any register restarts the
// sequence at its first pixel and should be done while idle.
module temporal_pixel_variance #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_FRAMES = 257
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_valid,
    output logic                           o_stall,
    input  wire  [tpv_pkg::PIX_W-1:0]      i_pixel,
    output logic                           o_valid,
    input  wire                            i_stall,
    output logic [tpv_pkg::VAR_W-1:0]      o_variance,
    output logic                           o_last,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire  [tpv_pkg::PADDR_W-1:0]    paddr,
    input  wire  [tpv_pkg::PDATA_W-1:0]    pwdata,
    output logic [tpv_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);
    import tpv_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    // Configuration
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [CNT_W-1:0] r_count;
    logic             cfg_we;
    logic             cfg_hit;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [CW-1:0]    w_m1;
    logic [RW-1:0]    h_m1;
    logic [FW-1:0]    f_m1;
    logic [CNT_W-1:0] n_val;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign reg_idx = paddr[REG_IDX_W+1:2];

    // Only a write that lands on a register restarts the sequence.
    always_comb begin
        case (reg_idx)
            REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_FRAME_COUNT: cfg_hit = cfg_we;
            default:                                            cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(1024);
            r_height <= DIM_W'(1024);
            r_count  <= CNT_W'(1);
        end else if (cfg_we) begin
            case (reg_idx)
                REG_FRAME_WIDTH:  r_width  <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: r_height <= pwdata[DIM_W-1:0];
                REG_FRAME_COUNT:  r_count  <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FRAME_WIDTH:  prdata = PDATA_W'(r_width);
            REG_FRAME_HEIGHT: prdata = PDATA_W'(r_height);
            REG_FRAME_COUNT:  prdata = PDATA_W'(r_count);
            default:          prdata = '0;
        endcase
    end

    // Zero counts as one and values above the maximum saturate.
    always_comb begin
        if (r_width == '0) begin
            w_m1 = '0;
        end else if (32'(r_width) > MAX_WIDTH) begin
            w_m1 = CW'(MAX_WIDTH - 1);
        end else begin
            w_m1 = CW'(r_width - DIM_W'(1));
        end
        if (r_height == '0) begin
            h_m1 = '0;
        end else if (32'(r_height) > MAX_HEIGHT) begin
            h_m1 = RW'(MAX_HEIGHT - 1);
        end else begin
            h_m1 = RW'(r_height - DIM_W'(1));
        end
        if (r_count == '0) begin
            f_m1 = '0;
        end else if (32'(r_count) > MAX_FRAMES) begin
            f_m1 = FW'(MAX_FRAMES - 1);
        end else begin
            f_m1 = FW'(r_count - CNT_W'(1));
        end
    end

    assign n_val = CNT_W'(f_m1) + CNT_W'(1);

    // Raster position and frame counters
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [AW-1:0] r_pos, n_pos;
    logic [FW-1:0] r_frame, n_frame;
    logic          end_row;
    logic          end_frame;
    logic          in_accept;
    t_tag          in_tag;

    assign end_row   = (r_col == w_m1);
    assign end_frame = end_row && (r_row == h_m1);

    always_comb begin
        n_col   = r_col + CW'(1);
        n_row   = r_row;
        n_pos   = r_pos + AW'(1);
        n_frame = r_frame;
        if (end_row) begin
            n_col = '0;
            n_row = r_row + RW'(1);
            if (end_frame) begin
                n_row   = '0;
                n_pos   = '0;
                n_frame = (r_frame == f_m1) ? '0 : r_frame + FW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_col   <= '0;
            r_row   <= '0;
            r_pos   <= '0;
            r_frame <= '0;
        end else if (in_accept) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_pos   <= n_pos;
            r_frame <= n_frame;
        end
    end

    assign in_tag.first = (r_frame == '0);
    assign in_tag.emit  = (r_frame == f_m1);
    assign in_tag.fin   = end_frame;

    // Stage 1: store read, update and write-back
    logic             acc_ready;
    logic             acc_valid;
    logic [SUM_W-1:0] acc_sum;
    logic [SQ_W-1:0]  acc_sq;
    t_tag             acc_tag;
    logic             ready2, ready3, ready4;

    assign o_stall   = !acc_ready;
    assign in_accept = i_valid && acc_ready;

    tpv_accum #(
        .DEPTH (DEPTH)
    ) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (acc_ready),
        .i_addr  (r_pos),
        .i_pixel (i_pixel),
        .i_tag   (in_tag),
        .o_valid (acc_valid),
        .i_ready (ready2),
        .o_sum   (acc_sum),
        .o_sq    (acc_sq),
        .o_tag   (acc_tag)
    );

    // Stages 2 to 4: sum capture, products, difference into the output register
    logic             r_v2, r_v3, r_v4;
    logic [SUM_W-1:0] r_sum2;
    logic [SQ_W-1:0]  r_sq2;
    logic             r_fin2, r_fin3;
    logic [VAR_W-1:0] r_prod_nsq, r_prod_ss;
    logic [VAR_W-1:0] r_var;
    logic             r_last;

    assign ready4 = !r_v4 || !i_stall;
    assign ready3 = !r_v3 || ready4;
    assign ready2 = !r_v2 || ready3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (ready2) begin
                r_v2 <= acc_valid && acc_tag.emit;
            end
            if (ready3) begin
                r_v3 <= r_v2;
            end
            if (ready4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Products are kept modulo 2^32; the true difference always fits.
    always_ff @(posedge i_clk) begin
        if (ready2) begin
            r_sum2 <= acc_sum;
            r_sq2  <= acc_sq;
            r_fin2 <= acc_tag.fin;
        end
        if (ready3) begin
            r_prod_nsq <= VAR_W'(n_val * r_sq2);
            r_prod_ss  <= VAR_W'(r_sum2 * r_sum2);
            r_fin3     <= r_fin2;
        end
        if (ready4) begin
            r_var  <= r_prod_nsq - r_prod_ss;
            r_last <= r_fin3;
        end
    end

    assign o_valid    = r_v4;
    assign o_variance = r_var;
    assign o_last     = r_last;

    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_hit |=> (r_pos == '0 && r_frame == '0 && r_col == '0 && r_row == '0))
        else $error("register write did not restart the sequence");

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= w_m1 && r_row <= h_m1)
        else $error("raster position beyond frame size");

    a_frame_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame <= f_m1)
        else $error("frame index beyond frame count");

    a_no_result_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_valid && ready2 && !acc_tag.emit) |=> !r_v2)
        else $error("result produced outside the last frame");

endmodule

`default_nettype wire
